FILE: hdl/lebfs_pkg.sv
// Types and constants shared by the eye blink and fade sequencer.
package lebfs_pkg;

   typedef enum logic [2:0] {
      PHASE_INIT,
      PHASE_WAKING,
      PHASE_WATCHING,
      PHASE_BLINKING,
      PHASE_SLEEPY,
      PHASE_SLEEPING,
      PHASE_STARING
   } phase_type;

   localparam logic [1:0] CSR_EYE_START = 2'd0;
   localparam logic [1:0] CSR_EYE_WIDTH = 2'd1;

   localparam logic [3:0] BLACK_INDEX = 4'd11;

   localparam logic [15:0] BLINK_BASE  = 16'd100;
   localparam logic [15:0] BLINK_RAND  = 16'd200;
   localparam logic [15:0] WATCH_BASE  = 16'd10000;
   localparam logic [15:0] WATCH_RAND  = 16'd25000;
   localparam logic [15:0] SLEEP_BASE  = 16'd1000;
   localparam logic [15:0] SLEEP_RAND  = 16'd6000;
   localparam logic [15:0] BLINKS_BASE = 16'd3;
   localparam logic [15:0] BLINKS_RAND = 16'd10;
   localparam logic [31:0] FADE_DELAY  = 32'd5;

   localparam logic [63:0] RECIP_ONE = 64'd1 << 32;
   localparam logic [17:0] RECIP_WATCH  = 18'(RECIP_ONE / 64'(WATCH_RAND));
   localparam logic [19:0] RECIP_SLEEP  = 20'(RECIP_ONE / 64'(SLEEP_RAND));
   localparam logic [24:0] RECIP_BLINK  = 25'(RECIP_ONE / 64'(BLINK_RAND));
   localparam logic [28:0] RECIP_BLINKS = 29'(RECIP_ONE / 64'(BLINKS_RAND));

   typedef struct packed {
      logic        func;
      logic [31:0] now_ms;
      logic [31:0] random_word;
      logic [2:0]  forced_phase;
   } item_type;

   typedef struct packed {
      item_type    item;
      logic [17:0] q_watch;
      logic [19:0] q_sleep;
      logic [24:0] q_blink;
      logic [28:0] q_blinks;
   } quot_type;

   typedef struct packed {
      item_type    item;
      logic [15:0] p_watch;
      logic [15:0] p_sleep;
      logic [15:0] p_blink;
      logic [15:0] p_blinks;
   } prod_type;

   typedef struct packed {
      item_type    item;
      logic [15:0] watch_dly;
      logic [12:0] sleep_dly;
      logic [8:0]  blink_dly;
      logic [3:0]  blinks;
   } delay_type;

   typedef struct packed {
      logic [7:0] start;
      logic [7:0] width;
      logic [7:0] level;
      logic [3:0] color;
   } fill_type;

endpackage

FILE: hdl/led_eye_blink_fade_sequencer_core.sv
// Eye blink and fade sequencer: random-delay pipeline, phase machine and fill command output.
//
// Takes one word per clock cycle while req_stall is low and shows its fill command, if any,
// in the result register. Three stages ahead of the phase update reduce the random word to
// its four draws by reciprocal multiplication; the phase machine and all its state live in
// the last stage, which writes the result register. The input side keeps taking words while
// a result waits, until the pipeline stages ahead of the result register are full.
module led_eye_blink_fade_sequencer_core #(
   parameter int MAX_LEVEL   = 204,
   parameter int COLOR_COUNT = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_random_word,
   input  logic [2:0]  req_forced_phase,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_fill_start,
   output logic [7:0]  rsp_fill_width,
   output logic [7:0]  rsp_fill_level,
   output logic [3:0]  rsp_fill_tint,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam logic [7:0] MaxLevel  = 8'(MAX_LEVEL);
   localparam logic [3:0] LastColor = 4'(COLOR_COUNT - 1);

   logic [7:0] eye_start_ff, eye_width_ff;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic ready1, ready2, ready3, ready4, out_free, go4;

   lebfs_pkg::item_type  s1_ff, s1_in;
   lebfs_pkg::quot_type  s2_ff, s2_in;
   lebfs_pkg::prod_type  s3_ff, s3_in;
   lebfs_pkg::delay_type s4_ff, s4_in;

   logic [49:0] prod_watch;
   logic [51:0] prod_sleep;
   logic [56:0] prod_blink;
   logic [60:0] prod_blinks;
   logic [15:0] rem_watch, rem_sleep, rem_blink, rem_blinks;
   logic [15:0] fix_watch, fix_sleep, fix_blink, fix_blinks;

   lebfs_pkg::phase_type phase_ff, phase_in;
   logic [31:0] deadline_ff, deadline_in;
   logic [7:0]  level_ff, level_in;
   logic [3:0]  blinks_left_ff, blinks_left_in;
   logic [3:0]  current_color_ff, current_color_in;
   logic [3:0]  color_next_ff, color_next_in;
   logic        emit;
   logic [3:0]  emit_color;

   logic                 rsp_valid_ff;
   lebfs_pkg::fill_type  fill_ff, fill_in;

   // pipeline flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign go4       = s4_valid_ff && out_free;
   assign ready4    = !s4_valid_ff || out_free;
   assign ready3    = !s3_valid_ff || ready4;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_stall = !ready1;

   // stage 1: capture word
   assign s1_in.func         = req_func;
   assign s1_in.now_ms       = req_now_ms;
   assign s1_in.random_word  = req_random_word;
   assign s1_in.forced_phase = req_forced_phase;

   // stage 2: approximate quotients
   always_comb begin
      prod_watch  = 50'(s1_ff.random_word) * 50'(lebfs_pkg::RECIP_WATCH);
      prod_sleep  = 52'(s1_ff.random_word) * 52'(lebfs_pkg::RECIP_SLEEP);
      prod_blink  = 57'(s1_ff.random_word) * 57'(lebfs_pkg::RECIP_BLINK);
      prod_blinks = 61'(s1_ff.random_word) * 61'(lebfs_pkg::RECIP_BLINKS);
      s2_in.item     = s1_ff;
      s2_in.q_watch  = prod_watch[49:32];
      s2_in.q_sleep  = prod_sleep[51:32];
      s2_in.q_blink  = prod_blink[56:32];
      s2_in.q_blinks = prod_blinks[60:32];
   end

   // stage 3: quotient times divisor, low bits only
   always_comb begin
      s3_in.item     = s2_ff.item;
      s3_in.p_watch  = 16'(s2_ff.q_watch[15:0] * lebfs_pkg::WATCH_RAND);
      s3_in.p_sleep  = 16'(s2_ff.q_sleep[15:0] * lebfs_pkg::SLEEP_RAND);
      s3_in.p_blink  = 16'(s2_ff.q_blink[15:0] * lebfs_pkg::BLINK_RAND);
      s3_in.p_blinks = 16'(s2_ff.q_blinks[15:0] * lebfs_pkg::BLINKS_RAND);
   end

   // stage 4: residues with one correction, plus base delays
   always_comb begin
      rem_watch  = s3_ff.item.random_word[15:0] - s3_ff.p_watch;
      rem_sleep  = s3_ff.item.random_word[15:0] - s3_ff.p_sleep;
      rem_blink  = s3_ff.item.random_word[15:0] - s3_ff.p_blink;
      rem_blinks = s3_ff.item.random_word[15:0] - s3_ff.p_blinks;
      fix_watch  = (rem_watch >= lebfs_pkg::WATCH_RAND) ? rem_watch - lebfs_pkg::WATCH_RAND
                                                        : rem_watch;
      fix_sleep  = (rem_sleep >= lebfs_pkg::SLEEP_RAND) ? rem_sleep - lebfs_pkg::SLEEP_RAND
                                                        : rem_sleep;
      fix_blink  = (rem_blink >= lebfs_pkg::BLINK_RAND) ? rem_blink - lebfs_pkg::BLINK_RAND
                                                        : rem_blink;
      fix_blinks = (rem_blinks >= lebfs_pkg::BLINKS_RAND) ?
                   rem_blinks - lebfs_pkg::BLINKS_RAND : rem_blinks;
      s4_in.item      = s3_ff.item;
      s4_in.watch_dly = fix_watch + lebfs_pkg::WATCH_BASE;
      s4_in.sleep_dly = 13'(fix_sleep + lebfs_pkg::SLEEP_BASE);
      s4_in.blink_dly = 9'(fix_blink + lebfs_pkg::BLINK_BASE);
      s4_in.blinks    = 4'(fix_blinks + lebfs_pkg::BLINKS_BASE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (ready1) s1_valid_ff <= req_valid;
         if (ready2) s2_valid_ff <= s1_valid_ff;
         if (ready3) s3_valid_ff <= s2_valid_ff;
         if (ready4) s4_valid_ff <= s3_valid_ff;
      end
      if (ready1 && req_valid)   s1_ff <= s1_in;
      if (ready2 && s1_valid_ff) s2_ff <= s2_in;
      if (ready3 && s2_valid_ff) s3_ff <= s3_in;
      if (ready4 && s3_valid_ff) s4_ff <= s4_in;
   end

   // phase machine
   always_comb begin
      phase_in         = phase_ff;
      deadline_in      = deadline_ff;
      level_in         = level_ff;
      blinks_left_in   = blinks_left_ff;
      current_color_in = current_color_ff;
      color_next_in    = color_next_ff;
      emit             = 1'b0;
      emit_color       = current_color_ff;
      if (s4_ff.item.func) begin
         phase_in    = lebfs_pkg::phase_type'(s4_ff.item.forced_phase);
         deadline_in = s4_ff.item.now_ms;
      end else if (deadline_ff < s4_ff.item.now_ms) begin
         case (phase_ff)
            lebfs_pkg::PHASE_INIT: begin
               current_color_in = color_next_ff;
               color_next_in    = (color_next_ff >= LastColor) ? 4'd0 : color_next_ff + 4'd1;
               blinks_left_in   = s4_ff.blinks;
               phase_in         = lebfs_pkg::PHASE_WAKING;
            end
            lebfs_pkg::PHASE_WAKING: begin
               deadline_in = s4_ff.item.now_ms + lebfs_pkg::FADE_DELAY;
               if (level_ff < MaxLevel) begin
                  level_in = level_ff + 8'd1;
                  emit     = 1'b1;
               end else begin
                  phase_in = lebfs_pkg::PHASE_WATCHING;
               end
            end
            lebfs_pkg::PHASE_WATCHING: begin
               deadline_in = s4_ff.item.now_ms + 32'(s4_ff.watch_dly);
               phase_in    = (blinks_left_ff == 4'd0) ? lebfs_pkg::PHASE_SLEEPY
                                                      : lebfs_pkg::PHASE_BLINKING;
               emit        = 1'b1;
            end
            lebfs_pkg::PHASE_BLINKING: begin
               blinks_left_in = blinks_left_ff - 4'd1;
               deadline_in    = s4_ff.item.now_ms + 32'(s4_ff.blink_dly);
               phase_in       = lebfs_pkg::PHASE_WATCHING;
               emit           = 1'b1;
               emit_color     = lebfs_pkg::BLACK_INDEX;
            end
            lebfs_pkg::PHASE_SLEEPY: begin
               deadline_in = s4_ff.item.now_ms + lebfs_pkg::FADE_DELAY;
               if (level_ff != 8'd0) begin
                  level_in = level_ff - 8'd1;
                  emit     = 1'b1;
               end else begin
                  phase_in = lebfs_pkg::PHASE_SLEEPING;
               end
            end
            lebfs_pkg::PHASE_SLEEPING: begin
               deadline_in = s4_ff.item.now_ms + 32'(s4_ff.sleep_dly);
               phase_in    = lebfs_pkg::PHASE_INIT;
               emit        = 1'b1;
               emit_color  = lebfs_pkg::BLACK_INDEX;
            end
            lebfs_pkg::PHASE_STARING: begin
               level_in = MaxLevel;
               emit     = 1'b1;
            end
            default: begin
            end
         endcase
      end
      fill_in.start = eye_start_ff;
      fill_in.width = eye_width_ff;
      fill_in.level = level_in;
      fill_in.color = emit_color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= lebfs_pkg::PHASE_INIT;
         deadline_ff      <= 32'd0;
         level_ff         <= MaxLevel;
         blinks_left_ff   <= 4'd0;
         current_color_ff <= 4'd0;
         color_next_ff    <= 4'd0;
      end else if (go4) begin
         phase_ff         <= phase_in;
         deadline_ff      <= deadline_in;
         level_ff         <= level_in;
         blinks_left_ff   <= blinks_left_in;
         current_color_ff <= current_color_in;
         color_next_ff    <= color_next_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go4) begin
         rsp_valid_ff <= emit;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (go4 && emit) fill_ff <= fill_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fill_start = fill_ff.start;
   assign rsp_fill_width = fill_ff.width;
   assign rsp_fill_level = fill_ff.level;
   assign rsp_fill_tint  = fill_ff.color;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         eye_start_ff <= 8'd0;
         eye_width_ff <= 8'd2;
      end else if (csr_write) begin
         case (csr_index)
            lebfs_pkg::CSR_EYE_START: eye_start_ff <= csr_wdata;
            lebfs_pkg::CSR_EYE_WIDTH: eye_width_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   a_color_range: assert property (@(posedge clock) disable iff (reset)
      current_color_ff <= LastColor && color_next_ff <= LastColor)
      else $error("color counter out of palette range");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= MaxLevel)
      else $error("level above maximum");

   a_draw_range: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> s4_ff.watch_dly < lebfs_pkg::WATCH_BASE + lebfs_pkg::WATCH_RAND
                      && 16'(s4_ff.sleep_dly) < lebfs_pkg::SLEEP_BASE + lebfs_pkg::SLEEP_RAND
                      && 16'(s4_ff.blink_dly) < lebfs_pkg::BLINK_BASE + lebfs_pkg::BLINK_RAND
                      && 16'(s4_ff.blinks) < lebfs_pkg::BLINKS_BASE + lebfs_pkg::BLINKS_RAND)
      else $error("random draw residue out of range");

   a_forced_silent: assert property (@(posedge clock) disable iff (reset)
      go4 && s4_ff.item.func |=> !rsp_valid_ff)
      else $error("forced phase change produced a fill command");

endmodule

FILE: dv/tb_led_eye_blink_fade_sequencer_core.sv
// Self-checking testbench for the LED eye blink and fade sequencer core.
`timescale 1ns / 1ps

module tb_led_eye_blink_fade_sequencer_core;

   localparam int MAX_LEVEL   = 204;
   localparam int COLOR_COUNT = 11;

   localparam logic FUNC_STEP  = 1'b0;
   localparam logic FUNC_FORCE = 1'b1;

   localparam logic [2:0] PHASE_FROZEN = 3'd7;

   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   localparam logic [31:0] BLINK_MIN   = 32'd100;
   localparam logic [31:0] BLINK_SPAN  = 32'd200;
   localparam logic [31:0] WATCH_MIN   = 32'd10000;
   localparam logic [31:0] WATCH_SPAN  = 32'd25000;
   localparam logic [31:0] SLEEP_MIN   = 32'd1000;
   localparam logic [31:0] SLEEP_SPAN  = 32'd6000;
   localparam logic [31:0] BLINKS_MIN  = 32'd3;
   localparam logic [31:0] BLINKS_SPAN = 32'd10;
   localparam logic [31:0] FADE_MS     = 32'd5;

   localparam logic [31:0] ALL_ONES  = '1;
   localparam logic [7:0]  TOP_LEVEL = 8'(MAX_LEVEL);
   localparam logic [3:0]  BLACK     = lebfs_pkg::BLACK_INDEX;

   localparam int EYE_SETUPS      = 5;
   localparam int WORDS_PER_SETUP = 255;
   localparam int LONG_HOLD       = 400;
   localparam int DRAIN_CYCLES    = 8;
   localparam int SETTLE_LIMIT    = 20000;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_FILL
   } check_kind_type;

   typedef struct packed {
      lebfs_pkg::item_type w;
      check_kind_type      chk;
      lebfs_pkg::fill_type fill;
   } plan_row_type;

   localparam lebfs_pkg::fill_type NO_FILL = '0;

   localparam plan_row_type PLAN [25] = '{
      '{'{FUNC_STEP,  32'd0,         32'd0,    lebfs_pkg::PHASE_INIT}, CHK_NONE, NO_FILL},
      '{'{FUNC_FORCE, 32'd0,         ALL_ONES, lebfs_pkg::PHASE_BLINKING}, CHK_NONE, NO_FILL},
      '{'{FUNC_STEP,  32'd1,         32'd0,    lebfs_pkg::PHASE_INIT}, CHK_FILL,
        '{8'd0, 8'd2, TOP_LEVEL, BLACK}},
      '{'{FUNC_STEP,  32'd101,       32'd0,    lebfs_pkg::PHASE_STARING}, CHK_NONE, NO_FILL},
      '{'{FUNC_STEP,  32'd102,       32'd0,    lebfs_pkg::PHASE_INIT}, CHK_FILL,
        '{8'd0, 8'd2, TOP_LEVEL, 4'd0}},
      '{'{FUNC_FORCE, 32'd200,       32'd0,    lebfs_pkg::PHASE_INIT}, CHK_NONE, NO_FILL},
      '{'{FUNC_STEP,  32'd201,       32'd0,    lebfs_pkg::PHASE_INIT}, CHK_NONE, NO_FILL},
      '{'{FUNC_STEP,  32'd202,       ALL_ONES, lebfs_pkg::PHASE_INIT}, CHK_NONE, NO_FILL},
      '{'{FUNC_STEP,  32'd207,       32'd0,    lebfs_pkg::PHASE_INIT}, CHK_NONE, NO_FILL},
      '{'{FUNC_STEP,  32'd208,       ALL_ONES, lebfs_pkg::PHASE_INIT}, CHK_FILL,
        '{8'd0, 8'd2, TOP_LEVEL, 4'd0}},
      '{'{FUNC_FORCE, 32'hFFFF_FFFE, 32'd0,    lebfs_pkg::PHASE_STARING}, CHK_NONE, NO_FILL},
      '{'{FUNC_STEP,  ALL_ONES,      ALL_ONES, lebfs_pkg::PHASE_INIT}, CHK_FILL,
        '{8'd0, 8'd2, TOP_LEVEL, 4'd0}},
      '{'{FUNC_STEP,  ALL_ONES,      32'd0,    lebfs_pkg::PHASE_INIT}, CHK_FILL,
        '{8'd0, 8'd2, TOP_LEVEL, 4'd0}},
      '{'{FUNC_FORCE, 32'd0,         32'd0,    PHASE_FROZEN}, CHK_NONE, NO_FILL},
      '{'{FUNC_STEP,  ALL_ONES,      ALL_ONES, PHASE_FROZEN}, CHK_NONE, NO_FILL},
      '{'{FUNC_FORCE, 32'd0,         32'd0,    lebfs_pkg::PHASE_SLEEPY}, CHK_NONE, NO_FILL},
      '{'{FUNC_STEP,  32'd1,         32'd0,    lebfs_pkg::PHASE_INIT}, CHK_FILL,
        '{8'd0, 8'd2, TOP_LEVEL - 8'd1, 4'd0}},
      '{'{FUNC_FORCE, 32'd10,        32'd0,    lebfs_pkg::PHASE_SLEEPING}, CHK_NONE, NO_FILL},
      '{'{FUNC_STEP,  32'd11,        ALL_ONES, lebfs_pkg::PHASE_INIT}, CHK_FILL,
        '{8'd0, 8'd2, TOP_LEVEL - 8'd1, BLACK}},
      '{'{FUNC_STEP,  32'd6307,      32'd7,    lebfs_pkg::PHASE_INIT}, CHK_MODEL, NO_FILL},
      '{'{FUNC_FORCE, 32'hFFFF_FFFC, 32'd0,    lebfs_pkg::PHASE_WAKING}, CHK_MODEL, NO_FILL},
      '{'{FUNC_STEP,  32'hFFFF_FFFD, 32'd0,    lebfs_pkg::PHASE_INIT}, CHK_MODEL, NO_FILL},
      '{'{FUNC_STEP,  32'd3,         32'd0,    lebfs_pkg::PHASE_INIT}, CHK_MODEL, NO_FILL},
      '{'{FUNC_STEP,  32'd9,         32'd0,    lebfs_pkg::PHASE_INIT}, CHK_MODEL, NO_FILL},
      '{'{FUNC_FORCE, ALL_ONES,      32'd0,    lebfs_pkg::PHASE_WATCHING}, CHK_NONE, NO_FILL}
   };

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_func         = 1'b0;
   logic [31:0] req_now_ms       = '0;
   logic [31:0] req_random_word  = '0;
   logic [2:0]  req_forced_phase = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_fill_start;
   logic [7:0]  rsp_fill_width;
   logic [7:0]  rsp_fill_level;
   logic [3:0]  rsp_fill_tint;
   logic        csr_write        = 1'b0;
   logic [1:0]  csr_index        = '0;
   logic [7:0]  csr_wdata        = '0;

   // predictor state
   logic [2:0]  mood     = lebfs_pkg::PHASE_INIT;
   logic [31:0] due_at   = '0;
   logic [7:0]  glow     = TOP_LEVEL;
   logic [3:0]  blinks   = '0;
   logic [3:0]  hue      = '0;
   logic [3:0]  hue_next = '0;
   logic [7:0]  eye_at   = 8'd0;
   logic [7:0]  eye_span = 8'd2;

   lebfs_pkg::fill_type fills_due [$];

   int   mismatches    = 0;
   int   words_sent    = 0;
   int   fills_checked = 0;
   int   forces        = 0;
   int   hold_requests = 0;
   int   holds_done    = 0;
   logic [7:0] acted_mask = '0;
   bit   tx_calm = 1'b0;
   bit   rx_calm = 1'b0;

   led_eye_blink_fade_sequencer_core #(
      .MAX_LEVEL   (MAX_LEVEL),
      .COLOR_COUNT (COLOR_COUNT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_now_ms       (req_now_ms),
      .req_random_word  (req_random_word),
      .req_forced_phase (req_forced_phase),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fill_start   (rsp_fill_start),
      .rsp_fill_width   (rsp_fill_width),
      .rsp_fill_level   (rsp_fill_level),
      .rsp_fill_tint    (rsp_fill_tint),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic int pick_gap(inout bit calm);
      int roll;
      if ($urandom_range(0, 99) == 0) calm = !calm;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit predict_fill(input lebfs_pkg::item_type w,
                                       output lebfs_pkg::fill_type f);
      bit         fires;
      logic [3:0] paint;
      fires = 1'b0;
      f = '0;
      if (w.func == FUNC_FORCE) begin
         mood = w.forced_phase;
         due_at = w.now_ms;
         forces++;
         return 1'b0;
      end
      if (!(due_at < w.now_ms) || mood == PHASE_FROZEN) return 1'b0;
      acted_mask[mood] = 1'b1;
      paint = 4'(hue % COLOR_COUNT);
      case (mood)
         lebfs_pkg::PHASE_INIT: begin
            hue = hue_next;
            hue_next = 4'((hue_next + 1) % COLOR_COUNT);
            blinks = 4'(BLINKS_MIN + w.random_word % BLINKS_SPAN);
            mood = lebfs_pkg::PHASE_WAKING;
         end
         lebfs_pkg::PHASE_WAKING: begin
            due_at = w.now_ms + FADE_MS;
            if (glow < MAX_LEVEL) begin
               glow = glow + 8'd1;
               fires = 1'b1;
            end else begin
               mood = lebfs_pkg::PHASE_WATCHING;
            end
         end
         lebfs_pkg::PHASE_WATCHING: begin
            due_at = w.now_ms + WATCH_MIN + w.random_word % WATCH_SPAN;
            mood = (blinks == 4'd0) ? lebfs_pkg::PHASE_SLEEPY : lebfs_pkg::PHASE_BLINKING;
            fires = 1'b1;
         end
         lebfs_pkg::PHASE_BLINKING: begin
            blinks = blinks - 4'd1;
            due_at = w.now_ms + BLINK_MIN + w.random_word % BLINK_SPAN;
            mood = lebfs_pkg::PHASE_WATCHING;
            paint = BLACK;
            fires = 1'b1;
         end
         lebfs_pkg::PHASE_SLEEPY: begin
            due_at = w.now_ms + FADE_MS;
            if (glow != 8'd0) begin
               glow = glow - 8'd1;
               fires = 1'b1;
            end else begin
               mood = lebfs_pkg::PHASE_SLEEPING;
            end
         end
         lebfs_pkg::PHASE_SLEEPING: begin
            due_at = w.now_ms + SLEEP_MIN + w.random_word % SLEEP_SPAN;
            mood = lebfs_pkg::PHASE_INIT;
            paint = BLACK;
            fires = 1'b1;
         end
         lebfs_pkg::PHASE_STARING: begin
            glow = TOP_LEVEL;
            fires = 1'b1;
         end
         default: ;
      endcase
      f = '{eye_at, eye_span, glow, paint};
      return fires;
   endfunction

   function automatic lebfs_pkg::item_type next_stimulus(input int force_pct);
      lebfs_pkg::item_type w;
      int                  pick;
      w.func = FUNC_STEP;
      w.random_word = $urandom;
      w.forced_phase = 3'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < force_pct) begin
         w.func = FUNC_FORCE;
         w.forced_phase = ($urandom_range(0, 15) == 0) ? PHASE_FROZEN
                                                       : 3'($urandom_range(0, 6));
         w.now_ms = ($urandom_range(0, 3) == 0) ? $urandom : due_at + $urandom_range(0, 50);
      end else if (pick < 80) begin
         w.now_ms = due_at + 32'd1 + $urandom_range(0, 3);
      end else if (pick < 95) begin
         w.now_ms = due_at - $urandom_range(0, 2);
      end else begin
         w.now_ms = $urandom;
      end
      return w;
   endfunction

   task automatic send_word(input lebfs_pkg::item_type w, input check_kind_type chk,
                            input lebfs_pkg::fill_type typed);
      int                  gap;
      bit                  fires;
      lebfs_pkg::fill_type f;
      gap = pick_gap(tx_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= w.func;
      req_now_ms       <= w.now_ms;
      req_random_word  <= w.random_word;
      req_forced_phase <= w.forced_phase;
      do @(posedge clock); while (req_stall);
      words_sent++;
      fires = predict_fill(w, f);
      if (chk == CHK_FILL) fills_due.push_back(typed);
      else if (chk == CHK_MODEL && fires) fills_due.push_back(f);
   endtask

   task automatic write_eye(input logic [7:0] start, input logic [7:0] width);
      csr_write <= 1'b1;
      csr_index <= lebfs_pkg::CSR_EYE_START;
      csr_wdata <= start;
      @(posedge clock);
      eye_at = start;
      csr_index <= lebfs_pkg::CSR_EYE_WIDTH;
      csr_wdata <= width;
      @(posedge clock);
      eye_span = width;
      // spare index: must be ignored
      csr_index <= $urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO;
      csr_wdata <= 8'($urandom);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      while (fills_due.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_fill();
      lebfs_pkg::fill_type want;
      if (fills_due.size() == 0) begin
         $error("fill word with none expected: start %0d width %0d level %0d tint %0d",
                rsp_fill_start, rsp_fill_width, rsp_fill_level, rsp_fill_tint);
         mismatches++;
         return;
      end
      want = fills_due.pop_front();
      fills_checked++;
      if (rsp_fill_start !== want.start) begin
         $error("fill_start expected %0d actual %0d", want.start, rsp_fill_start);
         mismatches++;
      end
      if (rsp_fill_width !== want.width) begin
         $error("fill_width expected %0d actual %0d", want.width, rsp_fill_width);
         mismatches++;
      end
      if (rsp_fill_level !== want.level) begin
         $error("fill_level expected %0d actual %0d", want.level, rsp_fill_level);
         mismatches++;
      end
      if (rsp_fill_tint !== want.color) begin
         $error("fill_tint expected %0d actual %0d", want.color, rsp_fill_tint);
         mismatches++;
      end
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_fill();
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            stall_left = LONG_HOLD;
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap(rx_calm);
         end
      end
   end

   initial begin
      logic [7:0] starts [EYE_SETUPS];
      logic [7:0] widths [EYE_SETUPS];
      int         force_pct [EYE_SETUPS];
      starts    = '{8'd255, 8'd0,   8'd255, 8'($urandom), 8'd0};
      widths    = '{8'd0,   8'd255, 8'd255, 8'($urandom), 8'd1};
      force_pct = '{1, 6, 2, 10, 4};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (PLAN[i]) send_word(PLAN[i].w, PLAN[i].chk, PLAN[i].fill);
      req_valid <= 1'b0;
      settle();

      for (int s = 0; s < EYE_SETUPS; s++) begin
         write_eye(starts[s], widths[s]);
         if (s == 0 || s == 2) hold_requests++;
         for (int n = 0; n < WORDS_PER_SETUP; n++) begin
            send_word(next_stimulus(force_pct[s]), CHK_MODEL, NO_FILL);
         end
         req_valid <= 1'b0;
         settle();
      end

      if (fills_due.size() != 0) begin
         $error("%0d expected fill words never arrived", fills_due.size());
         mismatches += fills_due.size();
      end
      $display("sent %0d words (%0d forced phase changes), checked %0d fill words",
               words_sent, forces, fills_checked);
      $display("%0d eye placements, phases that acted on a time step: %b",
               EYE_SETUPS + 1, acted_mask[6:0]);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
